/* rtl/asm_pkg.sv */
// Shared constants, codes and types of the address space slot manager.
`default_nettype none

package asm_pkg;

   localparam int SLOTS        = 256;
   localparam int PAGE_SHIFT   = 16;
   localparam int REGION_SHIFT = 36;
   localparam int OWNER_BITS   = 32;

   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int HEAD_W   = $clog2(SLOTS + 1);
   localparam int ADDR_W   = 64;
   localparam int IDX_W    = ADDR_W - REGION_SHIFT;
   localparam int PAGES_W  = 21;
   localparam int RANGE_W  = 37;
   localparam int OWNER_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 3;

   localparam logic [HEAD_W-1:0] NO_SLOT = HEAD_W'(SLOTS);
   localparam logic [PAGES_W:0]  PAGE_LIMIT =
      (PAGES_W + 1)'(64'd1 << (REGION_SHIFT - PAGE_SHIFT));

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 3'd0,
      OP_UNREGISTER = 3'd1,
      OP_GROW       = 3'd2,
      OP_SHRINK     = 3'd3,
      OP_RELEASE    = 3'd4,
      OP_LOOKUP     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_FREE  = 3'd1,
      ST_LIMIT    = 3'd2,
      ST_SHRINK   = 3'd3,
      ST_BAD_SLOT = 3'd4
   } status_type;

   typedef struct packed {
      logic [HEAD_W-1:0]     next;
      logic [OWNER_BITS-1:0] owner;
      logic [PAGES_W-1:0]    pages;
   } slot_entry_type;

   typedef struct packed {
      logic                next_en;
      logic                owner_en;
      logic                pages_en;
      logic [SLOT_W-1:0]   addr;
      slot_entry_type      data;
   } table_wr_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [OWNER_BITS-1:0] owner;
      logic [INDEX_W-1:0]    slot_index;
      logic [PAGES_W-1:0]    amount;
      logic [SLOT_W-1:0]     slot;
      logic                  in_range;
      logic [ADDR_W-1:0]     base;
   } stage_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   slot_out;
      logic [ADDR_W-1:0]    range_start;
      logic [RANGE_W-1:0]   range_bytes;
      logic [OWNER_W-1:0]   owner_out;
      logic [PAGES_W-1:0]   pages_now;
   } result_type;

   typedef struct packed {
      logic [HEAD_W-1:0] head;
      logic              use_set;
      logic              use_clr;
      logic              link_set;
   } commit_type;

endpackage

`default_nettype wire

/* rtl/asm_slot_table.sv */
// Per-slot tables (free-list link, owner, page count) with registered read and write bypass.
`default_nettype none

module asm_slot_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [asm_pkg::SLOT_W-1:0]  rd_addr,
   input  asm_pkg::table_wr_type       wr,
   output asm_pkg::slot_entry_type     rd_data
);
   import asm_pkg::*;

   logic [HEAD_W-1:0]     next_ff  [SLOTS];
   logic [OWNER_BITS-1:0] owner_ff [SLOTS];
   logic [PAGES_W-1:0]    pages_ff [SLOTS];

   slot_entry_type    raw_ff;
   logic [SLOT_W-1:0] addr_ff;
   table_wr_type      fwd_ff;
   table_wr_type      fwd_in;

   always_ff @(posedge clock) begin
      if (wr.next_en) begin
         next_ff[wr.addr] <= wr.data.next;
      end
      if (wr.owner_en) begin
         owner_ff[wr.addr] <= wr.data.owner;
      end
      if (wr.pages_en) begin
         pages_ff[wr.addr] <= wr.data.pages;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         raw_ff.next  <= next_ff[rd_addr];
         raw_ff.owner <= owner_ff[rd_addr];
         raw_ff.pages <= pages_ff[rd_addr];
         addr_ff      <= rd_addr;
      end
   end

   // hold the write that lands on the same edge as the read
   assign fwd_in = rd_en ? wr : fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   always_comb begin
      rd_data = raw_ff;
      if (fwd_ff.next_en && (fwd_ff.addr == addr_ff)) begin
         rd_data.next = fwd_ff.data.next;
      end
      if (fwd_ff.owner_en && (fwd_ff.addr == addr_ff)) begin
         rd_data.owner = fwd_ff.data.owner;
      end
      if (fwd_ff.pages_en && (fwd_ff.addr == addr_ff)) begin
         rd_data.pages = fwd_ff.data.pages;
      end
   end

endmodule

`default_nettype wire

/* rtl/asm_op_exec.sv */
// Operation logic: status, result word, table writes and free-list update for one request.
`default_nettype none

module asm_op_exec (
   input  asm_pkg::stage_type          stage,
   input  asm_pkg::slot_entry_type     entry,
   input  logic                        slot_used,
   input  logic                        slot_linked,
   input  logic [asm_pkg::HEAD_W-1:0]  head,
   output asm_pkg::result_type         res,
   output asm_pkg::table_wr_type       wr,
   output asm_pkg::commit_type         cmt
);
   import asm_pkg::*;

   always_comb begin
      logic [PAGES_W:0]   grow_sum;
      logic [PAGES_W-1:0] shrink_left;
      logic [PAGES_W-1:0] off_pages;
      logic               slot_ok;
      logic               range_on;

      grow_sum    = {1'b0, entry.pages} + {1'b0, stage.amount};
      shrink_left = entry.pages - stage.amount;
      slot_ok     = (HEAD_W'(stage.slot_index) < NO_SLOT) && slot_used;
      off_pages   = '0;
      range_on    = 1'b0;

      res         = '0;
      res.status  = ST_OK;
      wr          = '0;
      wr.addr     = stage.slot;
      wr.data     = entry;
      cmt.head    = head;
      cmt.use_set = 1'b0;
      cmt.use_clr = 1'b0;
      cmt.link_set = 1'b0;

      case (op_type'(stage.op))
         OP_REGISTER: begin
            if (head >= NO_SLOT) begin
               res.status = ST_NO_FREE;
            end else begin
               res.slot_out    = INDEX_W'(stage.slot);
               res.range_start = stage.base;
               cmt.head        = slot_linked ? entry.next : head + HEAD_W'(1);
               cmt.use_set     = 1'b1;
               wr.owner_en     = 1'b1;
               wr.data.owner   = stage.owner;
               wr.pages_en     = 1'b1;
               wr.data.pages   = '0;
            end
         end
         OP_UNREGISTER, OP_GROW, OP_SHRINK, OP_RELEASE: begin
            res.slot_out = stage.slot_index;
            if (!slot_ok) begin
               res.status = ST_BAD_SLOT;
            end else begin
               res.pages_now = entry.pages;
               case (op_type'(stage.op))
                  OP_GROW: begin
                     if (grow_sum > PAGE_LIMIT) begin
                        res.status = ST_LIMIT;
                     end else begin
                        range_on        = 1'b1;
                        off_pages       = entry.pages;
                        res.range_bytes = RANGE_W'(ADDR_W'(stage.amount) << PAGE_SHIFT);
                        wr.pages_en     = 1'b1;
                        wr.data.pages   = grow_sum[PAGES_W-1:0];
                        res.pages_now   = grow_sum[PAGES_W-1:0];
                     end
                  end
                  OP_SHRINK: begin
                     if (stage.amount > entry.pages) begin
                        res.status = ST_SHRINK;
                     end else begin
                        range_on        = 1'b1;
                        off_pages       = shrink_left;
                        res.range_bytes = RANGE_W'(ADDR_W'(stage.amount) << PAGE_SHIFT);
                        wr.pages_en     = 1'b1;
                        wr.data.pages   = shrink_left;
                        res.pages_now   = shrink_left;
                     end
                  end
                  default: begin
                     range_on        = 1'b1;
                     res.range_bytes = RANGE_W'(ADDR_W'(entry.pages) << PAGE_SHIFT);
                     wr.pages_en     = 1'b1;
                     wr.data.pages   = '0;
                     res.pages_now   = '0;
                     if (op_type'(stage.op) == OP_UNREGISTER) begin
                        // push the slot back onto the free list
                        cmt.use_clr  = 1'b1;
                        cmt.link_set = 1'b1;
                        cmt.head     = HEAD_W'(stage.slot_index);
                        wr.next_en   = 1'b1;
                        wr.data.next = head;
                     end
                  end
               endcase
            end
         end
         OP_LOOKUP: begin
            if (!stage.in_range) begin
               res.status = ST_BAD_SLOT;
            end else begin
               res.slot_out = INDEX_W'(stage.slot);
               if (!slot_used) begin
                  res.status = ST_BAD_SLOT;
               end else begin
                  res.owner_out = OWNER_W'(entry.owner);
                  res.pages_now = entry.pages;
               end
            end
         end
         default: begin
            res.status = ST_BAD_SLOT;
         end
      endcase

      if (range_on) begin
         res.range_start = stage.base + (ADDR_W'(off_pages) << PAGE_SHIFT);
      end
   end

endmodule

`default_nettype wire

/* rtl/address_space_slot_manager.sv */
// Top level of the address space slot manager: request stage, slot state and result register.
//
// Request channel (req_*): one word per operation, taken when req_valid is high and
// req_stall is low. Result channel (rsp_*): one word per request, in order, taken when
// rsp_valid is high and rsp_stall is low. csr_space_base is written through csr_valid /
// csr_ready (always ready) and must only change while no request is in flight.
// Path: a taken request and its slot table read load the request stage; once the stage
// advances, its result word loads the result register and shows on rsp_* until taken.
// Throughput: one request per cycle while the result channel does not stall;
// the slot table read at the request edge plus the one-deep write bypass sets this, and
// the free-list head is resolved from the result being committed in the same cycle.
// Reset: synchronous, active high; every slot is free, none in use, the free list hands
// out slots in ascending order, space_base is zero. No clearing pass is run, so the
// block takes requests as soon as reset is released.
// Stall: while rsp_stall holds a finished result, one more request is taken into the
// request stage; after that req_stall is raised until the result register drains.
`default_nettype none

module address_space_slot_manager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [asm_pkg::OP_W-1:0]      req_operation,
   input  logic [asm_pkg::OWNER_W-1:0]   req_owner_handle,
   input  logic [asm_pkg::INDEX_W-1:0]   req_slot_index,
   input  logic [asm_pkg::PAGES_W-1:0]   req_page_amount,
   input  logic [asm_pkg::ADDR_W-1:0]    req_lookup_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [asm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [asm_pkg::INDEX_W-1:0]   rsp_slot_out,
   output logic [asm_pkg::ADDR_W-1:0]    rsp_range_start,
   output logic [asm_pkg::RANGE_W-1:0]   rsp_range_bytes,
   output logic [asm_pkg::OWNER_W-1:0]   rsp_owner_out,
   output logic [asm_pkg::PAGES_W-1:0]   rsp_pages_now,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [asm_pkg::ADDR_W-1:0]    csr_space_base
);
   import asm_pkg::*;

   logic [ADDR_W-1:0] space_base_ff, space_base_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [SLOTS-1:0]  in_use_ff, in_use_in;
   logic [SLOTS-1:0]  linked_ff, linked_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         stage_ff, stage_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              adv;
   logic              accept;
   logic [ADDR_W-1:0] lk_diff;
   logic [IDX_W-1:0]  lk_idx;
   logic [SLOT_W-1:0] sel_slot;

   slot_entry_type    entry;
   result_type        res;
   table_wr_type      exec_wr;
   table_wr_type      tbl_wr;
   commit_type        cmt;

   assign csr_ready = 1'b1;
   assign space_base_in = (csr_valid && csr_ready) ? csr_space_base : space_base_ff;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   assign head_in = adv ? cmt.head : head_ff;

   assign lk_diff = req_lookup_address - space_base_ff;
   assign lk_idx  = lk_diff[ADDR_W-1:REGION_SHIFT];

   always_comb begin
      case (op_type'(req_operation))
         OP_REGISTER: sel_slot = head_in[SLOT_W-1:0];
         OP_LOOKUP:   sel_slot = lk_idx[SLOT_W-1:0];
         default:     sel_slot = SLOT_W'(req_slot_index);
      endcase
   end

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.op         = req_operation;
         stage_in.owner      = OWNER_BITS'(req_owner_handle);
         stage_in.slot_index = req_slot_index;
         stage_in.amount     = req_page_amount;
         stage_in.slot       = sel_slot;
         stage_in.in_range   = (lk_idx < IDX_W'(SLOTS));
         stage_in.base       = space_base_ff + (ADDR_W'(sel_slot) << REGION_SHIFT);
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = adv || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = adv ? res : rsp_ff;

   always_comb begin
      tbl_wr          = exec_wr;
      tbl_wr.next_en  = exec_wr.next_en && adv;
      tbl_wr.owner_en = exec_wr.owner_en && adv;
      tbl_wr.pages_en = exec_wr.pages_en && adv;
   end

   always_comb begin
      in_use_in = in_use_ff;
      linked_in = linked_ff;
      if (adv && cmt.use_set) begin
         in_use_in[stage_ff.slot] = 1'b1;
      end
      if (adv && cmt.use_clr) begin
         in_use_in[stage_ff.slot] = 1'b0;
      end
      if (adv && cmt.link_set) begin
         linked_in[stage_ff.slot] = 1'b1;
      end
   end

   asm_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (sel_slot),
      .wr      (tbl_wr),
      .rd_data (entry)
   );

   asm_op_exec u_exec (
      .stage       (stage_ff),
      .entry       (entry),
      .slot_used   (in_use_ff[stage_ff.slot]),
      .slot_linked (linked_ff[stage_ff.slot]),
      .head        (head_ff),
      .res         (res),
      .wr          (exec_wr),
      .cmt         (cmt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         space_base_ff <= '0;
         head_ff       <= '0;
         in_use_ff     <= '0;
         linked_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         space_base_ff <= space_base_in;
         head_ff       <= head_in;
         in_use_ff     <= in_use_in;
         linked_ff     <= linked_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_slot_out    = rsp_ff.slot_out;
   assign rsp_range_start = rsp_ff.range_start;
   assign rsp_range_bytes = rsp_ff.range_bytes;
   assign rsp_owner_out   = rsp_ff.owner_out;
   assign rsp_pages_now   = rsp_ff.pages_now;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   a_grant_free_slot: assert property (@(posedge clock) disable iff (reset)
      (adv && cmt.use_set) |-> !in_use_ff[stage_ff.slot])
      else $error("free list granted a slot already in use");

   a_push_sets_head: assert property (@(posedge clock) disable iff (reset)
      (adv && cmt.use_clr) |=> (head_ff == $past(HEAD_W'(stage_ff.slot_index))))
      else $error("released slot is not the new free-list head");
`endif

endmodule

`default_nettype wire
